// ===== rtl/sha256_pkg.sv =====
package sha256_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned FILL_W    = 6;
    localparam int unsigned LEN_W     = 64;
    localparam int unsigned ROUND_W   = 6;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned SCHED_LEN = 16;
    localparam int unsigned HASH_LEN  = 8;

    localparam logic [BYTE_W-1:0]  PAD_BYTE   = 8'h80;
    localparam logic [BYTE_W-1:0]  ZERO_BYTE  = 8'h00;
    localparam logic [FILL_W-1:0]  LEN_POS    = 6'd56;
    localparam logic [FILL_W-1:0]  LAST_POS   = 6'd63;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;
    localparam logic [IDX_W-1:0]   LAST_IDX   = 3'd7;
    localparam logic [LEN_W-1:0]   BITS_PER_BYTE = 64'd8;

    localparam logic [WORD_W-1:0] IV_TABLE [HASH_LEN] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

// ===== rtl/sha256_if.sv =====
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/sha256_stream_hasher_core.sv =====
// SHA-256 over a byte stream. While gathering, the core takes one input transaction per
// cycle; each transaction may carry a byte and may close the message. When a 64-byte block
// fills, the input holds off: 64 rounds run through the single round unit (one round per
// cycle, message schedule in a 16-word shift line), then the result is folded into the
// hash. At the end of a message the padding bytes (0x80, zeros, 64-bit bit length) are
// shifted in one per cycle, giving one or two compressions, after which the eight digest
// words leave as eight output transactions, word 0 first. The input is not ready from the
// end marker until the last digest word is taken; the core then starts over from the
// initial hash.
module sha256_stream_hasher_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sha256_in_if.sink           i_msg,
    sha256_out_if.source        o_dig
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PAD,
        S_ROUND,
        S_SUM,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [WORD_W-1:0]   r_w    [SCHED_LEN];
    logic [WORD_W-1:0]   r_v    [HASH_LEN];
    logic [WORD_W-1:0]   r_hash [HASH_LEN];
    logic [FILL_W-1:0]   r_fill;
    logic [LEN_W-1:0]    r_bits;
    logic [ROUND_W-1:0]  r_round;
    logic [IDX_W-1:0]    r_idx;
    logic                r_padding;
    logic                r_first;
    logic                r_len_ok;
    logic                r_final;

    logic [WORD_W-1:0]   sched_word;
    logic [WORD_W-1:0]   t1;
    logic [WORD_W-1:0]   t2;
    logic [WORD_W-1:0]   choose;
    logic [WORD_W-1:0]   major;
    logic [BYTE_W-1:0]   pad_byte;
    logic [BYTE_W-1:0]   shift_byte;
    logic                in_accept;
    logic                block_full;
    logic                len_phase;

    assign in_accept  = i_msg.valid && i_msg.ready;
    assign block_full = (r_fill == LAST_POS);
    assign len_phase  = r_len_ok && !r_first && (r_fill >= LEN_POS);

    always_comb begin
        choose     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        major      = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        sched_word = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
        t1         = r_v[7] + big_sigma1(r_v[4]) + choose + K_TABLE[r_round] + r_w[0];
        t2         = big_sigma0(r_v[0]) + major;
        if (r_first) begin
            pad_byte = PAD_BYTE;
        end else if (len_phase) begin
            pad_byte = r_bits[LEN_W-1 -: BYTE_W];
        end else begin
            pad_byte = ZERO_BYTE;
        end
        shift_byte = (r_state == S_LOAD) ? i_msg.msg_byte : pad_byte;
    end

    assign i_msg.ready       = (r_state == S_LOAD);
    assign o_dig.valid       = (r_state == S_OUT);
    assign o_dig.digest_word = r_hash[0];
    assign o_dig.word_index  = r_idx;
    assign o_dig.last_word   = (r_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_fill    <= '0;
            r_bits    <= '0;
            r_round   <= '0;
            r_idx     <= '0;
            r_padding <= 1'b0;
            r_first   <= 1'b0;
            r_len_ok  <= 1'b0;
            r_final   <= 1'b0;
            for (int i = 0; i < HASH_LEN; i++) begin
                r_hash[i] <= IV_TABLE[i];
            end
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_accept) begin
                        if (i_msg.byte_present) begin
                            for (int i = 0; i < SCHED_LEN - 1; i++) begin
                                r_w[i] <= {r_w[i][WORD_W-BYTE_W-1:0],
                                           r_w[i+1][WORD_W-1 -: BYTE_W]};
                            end
                            r_w[SCHED_LEN-1] <= {r_w[SCHED_LEN-1][WORD_W-BYTE_W-1:0],
                                                 shift_byte};
                            r_fill <= FILL_W'(r_fill + 1'b1);
                            r_bits <= r_bits + BITS_PER_BYTE;
                        end
                        if (i_msg.end_of_message) begin
                            r_padding <= 1'b1;
                            r_first   <= 1'b1;
                        end
                        if (i_msg.byte_present && block_full) begin
                            r_v     <= r_hash;
                            r_round <= '0;
                            r_final <= 1'b0;
                            r_state <= S_ROUND;
                        end else if (i_msg.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    for (int i = 0; i < SCHED_LEN - 1; i++) begin
                        r_w[i] <= {r_w[i][WORD_W-BYTE_W-1:0],
                                   r_w[i+1][WORD_W-1 -: BYTE_W]};
                    end
                    r_w[SCHED_LEN-1] <= {r_w[SCHED_LEN-1][WORD_W-BYTE_W-1:0], shift_byte};
                    r_fill <= FILL_W'(r_fill + 1'b1);
                    if (r_first) begin
                        // length fits in this block only if the marker lands before it
                        r_first  <= 1'b0;
                        r_len_ok <= (r_fill < LEN_POS);
                    end
                    if (len_phase) begin
                        r_bits <= r_bits << BYTE_W;
                    end
                    if (block_full) begin
                        r_final <= r_len_ok && !r_first;
                        r_v     <= r_hash;
                        r_round <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < SCHED_LEN - 1; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[SCHED_LEN-1] <= sched_word;
                    r_v[0] <= t1 + t2;
                    r_v[1] <= r_v[0];
                    r_v[2] <= r_v[1];
                    r_v[3] <= r_v[2];
                    r_v[4] <= r_v[3] + t1;
                    r_v[5] <= r_v[4];
                    r_v[6] <= r_v[5];
                    r_v[7] <= r_v[6];
                    r_round <= ROUND_W'(r_round + 1'b1);
                    if (r_round == LAST_ROUND) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    for (int i = 0; i < HASH_LEN; i++) begin
                        r_hash[i] <= r_hash[i] + r_v[i];
                    end
                    if (r_final) begin
                        r_idx   <= '0;
                        r_state <= S_OUT;
                    end else if (r_padding) begin
                        // padding not finished (no room for the length, or marker not yet placed): one more block
                        r_len_ok <= 1'b1;
                        r_state  <= S_PAD;
                    end else begin
                        r_state <= S_LOAD;
                    end
                end
                S_OUT: begin
                    if (o_dig.ready) begin
                        // shift the digest out and refill with the initial hash
                        for (int i = 0; i < HASH_LEN - 1; i++) begin
                            r_hash[i] <= r_hash[i+1];
                        end
                        r_hash[HASH_LEN-1] <= IV_TABLE[r_idx];
                        r_idx <= IDX_W'(r_idx + 1'b1);
                        if (r_idx == LAST_IDX) begin
                            r_padding <= 1'b0;
                            r_final   <= 1'b0;
                            r_len_ok  <= 1'b0;
                            r_fill    <= '0;
                            r_bits    <= '0;
                            r_state   <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sha256_checker.sv =====
module sha256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_end,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word,
    input logic [2:0]  i_out_index,
    input logic        i_out_last
);

    // hold a stalled digest word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("digest word changed while stalled");

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while digest pending");

    a_index_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=>
            i_out_valid && (i_out_index == 3'($past(i_out_index) + 3'd1)))
        else $error("digest words out of order");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_index == 3'd7)))
        else $error("last word flag mismatch");

    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_end |=> !i_in_ready)
        else $error("input ready right after end of message");

endmodule

bind sha256_stream_hasher_core sha256_checker u_sha256_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_msg.valid),
    .i_in_ready  (i_msg.ready),
    .i_in_end    (i_msg.end_of_message),
    .i_out_valid (o_dig.valid),
    .i_out_ready (o_dig.ready),
    .i_out_word  (o_dig.digest_word),
    .i_out_index (o_dig.word_index),
    .i_out_last  (o_dig.last_word)
);

// ===== tb/sha256_digest_checker.sv =====
`timescale 1ns / 100ps

module sha256_digest_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sha256_in_if  msg_ch,
    sha256_out_if dig_ch,
    output int    o_fail_count,
    output int    o_pending
);

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam int         LEN_OFFSET = 56;
    localparam int         BLOCK_LEN  = 64;

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_txn;

    logic [7:0]  block_bytes [BLOCK_LEN];
    int          fill_level;
    logic [63:0] bit_length;
    logic [31:0] chain_hash [8];
    t_digest_txn digest_due [$];
    t_digest_txn due_word;
    int          mismatches;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_message();
        fill_level = 0;
        bit_length = '0;
        for (int i = 0; i < 8; i++)
            chain_hash[i] = START_HASH[i];
    endfunction

    // Fold the current 64-byte block into the chaining hash.
    function automatic void compress_block_bytes();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] e;
        logic [31:0] a;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        for (int i = 0; i < 8; i++)
            v[i] = chain_hash[i];
        for (int i = 0; i < 64; i++) begin
            e  = v[4];
            a  = v[0];
            t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
               + ((e & v[5]) ^ (~e & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_hash[i] = chain_hash[i] + v[i];
    endfunction

    function automatic void absorb_txn(input logic [7:0] data, input logic present,
                                       input logic eom);
        int pos;
        if (present) begin
            block_bytes[fill_level] = data;
            fill_level = fill_level + 1;
            bit_length = bit_length + 64'd8;
            if (fill_level == BLOCK_LEN) begin
                compress_block_bytes();
                fill_level = 0;
            end
        end
        if (eom) begin
            pos = fill_level;
            block_bytes[pos] = PAD_MARK;
            pos = pos + 1;
            // no room for the length: spill into a second block
            if (pos > LEN_OFFSET) begin
                while (pos < BLOCK_LEN) begin
                    block_bytes[pos] = 8'h00;
                    pos = pos + 1;
                end
                compress_block_bytes();
                pos = 0;
            end
            while (pos < LEN_OFFSET) begin
                block_bytes[pos] = 8'h00;
                pos = pos + 1;
            end
            for (int i = 0; i < 8; i++)
                block_bytes[LEN_OFFSET + i] = bit_length[63 - 8*i -: 8];
            compress_block_bytes();
            for (int i = 0; i < 8; i++)
                digest_due.push_back('{digest_word: chain_hash[i], word_index: 3'(i),
                                       last_word: (i == 7)});
            restart_message();
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_message();
            digest_due.delete();
            mismatches = 0;
        end else begin
            if (msg_ch.valid && msg_ch.ready)
                absorb_txn(msg_ch.msg_byte, msg_ch.byte_present, msg_ch.end_of_message);
            if (dig_ch.valid && dig_ch.ready) begin
                if (digest_due.size() == 0) begin
                    $error("unexpected digest transaction: word %h index %0d",
                           dig_ch.digest_word, dig_ch.word_index);
                    mismatches = mismatches + 1;
                end else begin
                    due_word = digest_due.pop_front();
                    if (dig_ch.digest_word !== due_word.digest_word) begin
                        $error("digest_word: expected %h, actual %h",
                               due_word.digest_word, dig_ch.digest_word);
                        mismatches = mismatches + 1;
                    end
                    if (dig_ch.word_index !== due_word.word_index) begin
                        $error("word_index: expected %0d, actual %0d",
                               due_word.word_index, dig_ch.word_index);
                        mismatches = mismatches + 1;
                    end
                    if (dig_ch.last_word !== due_word.last_word) begin
                        $error("last_word: expected %0b, actual %0b",
                               due_word.last_word, dig_ch.last_word);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= digest_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   words_pending;
    int   txns_counted;
    int   msg_count;
    int   hold_requests;
    bit   tx_gaps_on;
    bit   rx_stalls_on;

    sha256_in_if  msg_ch ();
    sha256_out_if dig_ch ();

    sha256_stream_hasher_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_ch),
        .o_dig   (dig_ch)
    );

    sha256_digest_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .msg_ch       (msg_ch),
        .dig_ch       (dig_ch),
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Digest receiver: random stalls, plus a long hold-off on request.
    initial begin
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left    = 0;
        dig_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = holds_served + 1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                dig_ch.ready <= 1'b0;
            end else begin
                dig_ch.ready <= !(rx_stalls_on && $urandom_range(99) < 12);
            end
        end
    end

    task automatic put_txn(input logic [7:0] data, input logic present, input logic eom);
        while (tx_gaps_on && $urandom_range(99) < 12) begin
            msg_ch.valid    <= 1'b0;
            msg_ch.msg_byte <= 8'($urandom);
            @(posedge i_clk);
        end
        msg_ch.valid          <= 1'b1;
        msg_ch.msg_byte       <= data;
        msg_ch.byte_present   <= present;
        msg_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (msg_ch.ready !== 1'b1)
            @(posedge i_clk);
        if (present || eom)
            txns_counted = txns_counted + 1;
    endtask

    task automatic send_message(input int len, input bit eom_on_byte);
        for (int n = 0; n < len; n++) begin
            // sprinkle ignored transactions between bytes
            if ($urandom_range(99) < 10)
                put_txn(8'($urandom), 1'b0, 1'b0);
            put_txn(8'($urandom), 1'b1, eom_on_byte && (n == len - 1));
        end
        if (!eom_on_byte || len == 0)
            put_txn(8'($urandom), 1'b0, 1'b1);
        msg_count = msg_count + 1;
    endtask

    initial begin
        int len;
        bit eom_on_byte;
        txns_counted          = 0;
        msg_count             = 0;
        hold_requests         = 0;
        tx_gaps_on            = 1'b1;
        rx_stalls_on          = 1'b1;
        i_rst_n               = 1'b0;
        msg_ch.valid          = 1'b0;
        msg_ch.msg_byte       = 8'h00;
        msg_ch.byte_present   = 1'b0;
        msg_ch.end_of_message = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        put_txn(8'hff, 1'b0, 1'b0);     // idle transaction
        put_txn(8'h5a, 1'b0, 1'b1);     // empty message
        put_txn(8'h00, 1'b1, 1'b1);     // single byte carrying the end marker
        put_txn(8'hff, 1'b1, 1'b0);
        put_txn(8'ha5, 1'b0, 1'b0);     // byte flagged absent, must be dropped
        put_txn(8'h80, 1'b1, 1'b0);
        put_txn(8'h3c, 1'b0, 1'b1);
        put_txn(8'h61, 1'b1, 1'b0);
        put_txn(8'h62, 1'b1, 1'b0);
        put_txn(8'h63, 1'b1, 1'b0);
        put_txn(8'hff, 1'b0, 1'b1);
        put_txn(8'h00, 1'b0, 1'b1);     // empty again right after a digest

        while (txns_counted < 160 || msg_count < 5) begin
            // stall the receiver long enough to back up the input
            if (msg_count == 1)
                hold_requests <= hold_requests + 1;
            tx_gaps_on   = !(msg_count >= 3 && msg_count <= 5);
            rx_stalls_on <= !(msg_count >= 3 && msg_count <= 5);
            case ($urandom_range(9))
                4:       len = $urandom_range(57, 55);
                5:       len = $urandom_range(66, 62);
                6:       len = $urandom_range(3, 0);
                7:       len = $urandom_range(121, 118);
                8, 9:    len = $urandom_range(80, 0);
                default: len = $urandom_range(12, 0);
            endcase
            eom_on_byte = $urandom_range(1);
            send_message(len, eom_on_byte);
        end
        msg_ch.valid <= 1'b0;
        @(posedge i_clk);

        while (words_pending != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && words_pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sha256_pkg.sv
rtl/sha256_if.sv
rtl/sha256_stream_hasher_core.sv
rtl/sha256_checker.sv
tb/sha256_digest_checker.sv
tb/testbench.sv
